>>> hw/rtl/fdt_pkg.sv
// Shared constants and the pipeline payload type for the truncating float divider.
package fdt_pkg;

    localparam int unsigned StepsPerStage = 4;
    localparam int unsigned DivSteps      = 32;
    localparam int unsigned NumStages     = DivSteps / StepsPerStage;

    // Payload widths of the input and output channels.
    localparam int unsigned InWidth  = 64;
    localparam int unsigned OutWidth = 32;

    localparam logic [31:0] SeMask    = 32'hFF80_0000;
    localparam logic [31:0] FracMask  = 32'h007F_FFFF;
    localparam logic [31:0] HiddenBit = 32'h0080_0000;
    localparam logic [31:0] ExpBias   = 32'h3F80_0000;
    localparam logic [31:0] PosInf    = 32'h7F80_0000;
    localparam logic [31:0] QFrac     = 32'h7FFF_FF00;

    // Payload carried by every divide stage.
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [23:0] den;
        logic [31:0] se_diff;
        logic        flip;
        logic        special;
        logic [31:0] special_val;
    } stage_t;

endpackage

>>> hw/rtl/fdt_stream_if.sv
// Valid/ready stream interfaces for the operand pair and the quotient.
interface fdt_in_if;
    logic                         valid;
    logic                         ready;
    logic [fdt_pkg::InWidth-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fdt_out_if;
    logic                         valid;
    logic                         ready;
    logic [fdt_pkg::OutWidth-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/fdt_div_stage.sv
// One pipeline stage running four restoring divide steps.
module fdt_div_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  fdt_pkg::stage_t   in_data,
    output logic              in_ready,
    output logic              out_valid,
    output fdt_pkg::stage_t   out_data,
    input  logic              out_ready
);
    logic            valid_reg;
    fdt_pkg::stage_t data_reg;
    fdt_pkg::stage_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Four compare-subtract-shift steps on the partial remainder.
    always_comb
    begin
        logic [31:0] r;
        logic [31:0] q;
        logic        ge;
        data_next = in_data;
        r = in_data.rem;
        q = in_data.quo;
        for (int i = 0; i < fdt_pkg::StepsPerStage; i++)
        begin
            ge = r >= {8'd0, in_data.den};
            q  = {q[30:0], ge};
            if (ge)
            begin
                r = r - {8'd0, in_data.den};
            end
            r = {r[30:0], 1'b0};
        end
        data_next.rem = r;
        data_next.quo = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end
endmodule

>>> hw/rtl/float_divide_truncating_unit.sv
// Top level of the pipelined truncating single-precision divider.
//
//  channel | direction | payload
//  --------+-----------+------------------------------------------------
//  in_ch   | sink      | data[31:0] dividend_bits, data[63:32] divisor_bits
//  out_ch  | source    | data[31:0] quotient_bits
//
// The pipeline is an input register, eight divide stages of four
// steps each, and an output register that normalizes and packs.
// One transaction is accepted every cycle while the output is taken.
// Reset clears only the valid bits; payload registers are not reset.
// A stall on out_ch freezes each full stage with no empty stage after it; empty stages still fill.
module float_divide_truncating_unit (
    input  logic         clk,
    input  logic         rst_n,
    fdt_in_if.sink       in_ch,
    fdt_out_if.source    out_ch
);
    localparam int unsigned N = fdt_pkg::NumStages;

    logic            v   [N+1];
    logic            rdy [N+1];
    fdt_pkg::stage_t d   [N+1];

    logic            in_valid_reg;
    fdt_pkg::stage_t in_data_reg;
    fdt_pkg::stage_t in_next;
    logic            out_valid_reg;
    logic [31:0]     out_data_reg;
    logic [31:0]     out_next;
    logic            out_ready_int;
    logic            in_ready_int;
    logic [31:0]     a;
    logic [31:0]     b;

    assign a = in_ch.data[31:0];
    assign b = in_ch.data[63:32];

    // Operand decode: special cases, mantissas and exponent difference.
    always_comb
    begin
        in_next.rem         = (a & fdt_pkg::FracMask) | fdt_pkg::HiddenBit;
        in_next.quo         = 32'd0;
        in_next.den         = b[23:0] | fdt_pkg::HiddenBit[23:0];
        in_next.se_diff     = (a & fdt_pkg::SeMask) - (b & fdt_pkg::SeMask)
                              + fdt_pkg::ExpBias;
        in_next.flip        = a[31] ^ b[31];
        in_next.special     = (a[30:0] == 31'd0) || (b[30:0] == 31'd0);
        in_next.special_val = (a[30:0] == 31'd0) ? a : fdt_pkg::PosInf;
    end

    assign in_ready_int = !in_valid_reg || rdy[0];
    assign in_ch.ready  = in_ready_int;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready_int)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready_int && in_ch.valid)
        begin
            in_data_reg <= in_next;
        end
    end

    assign v[0] = in_valid_reg;
    assign d[0] = in_data_reg;

    // Divide pipeline.
    for (genvar s = 0; s < N; s++)
    begin : g_stage
        fdt_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[s]),
            .in_data   (d[s]),
            .in_ready  (rdy[s]),
            .out_valid (v[s+1]),
            .out_data  (d[s+1]),
            .out_ready (rdy[s+1])
        );
    end

    // Normalize, pack, check the sign of the wrapped exponent word and select the special-case result.
    always_comb
    begin
        logic        norm;
        logic [31:0] q;
        logic [31:0] r;
        norm = !d[N].quo[31];
        q    = norm ? {d[N].quo[30:0], 1'b0} : d[N].quo;
        r    = d[N].se_diff - (norm ? fdt_pkg::HiddenBit : 32'd0);
        r    = r | ((q & fdt_pkg::QFrac) >> 8);
        if (r[31] != d[N].flip)
        begin
            r = fdt_pkg::PosInf;
        end
        out_next = d[N].special ? d[N].special_val : r;
    end

    assign out_ready_int = !out_valid_reg || out_ch.ready;
    assign rdy[N]        = out_ready_int;
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.data   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready_int)
        begin
            out_valid_reg <= v[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready_int && v[N])
        begin
            out_data_reg <= out_next;
        end
    end

    // A stalled output freezes the last divide stage.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready && v[N]) |=> $stable(d[N]))
        else $error("last stage changed under stall");

    // A zero dividend yields a quotient whose magnitude bits are zero.
    a_zero_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (v[N] && out_ready_int && d[N].special && d[N].special_val[30:0] == 31'd0)
        |=> (out_data_reg[30:0] == 31'd0))
        else $error("zero dividend not preserved");

    // The quotient of hidden-bit mantissas always has one of its top two bits set.
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (v[N] && !d[N].special) |-> (d[N].quo[31] || d[N].quo[30]))
        else $error("mantissa quotient out of range");
endmodule

>>> bench/fdt_stream_if.sv
// The testbench uses the stream interfaces defined in the RTL interface file.

>>> bench/float_divide_truncating_unit_tb.sv
// Testbench for the truncating float divider: directed table, random pairs, scoreboard.
module float_divide_truncating_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NumRandom  = 800;
    localparam int unsigned LatencyCyc = 10;
    localparam int unsigned IdleLimit  = 2000;
    localparam int unsigned NumRows    = 19;

    typedef struct {
        logic [31:0] dividend;
        logic [31:0] divisor;
        logic        known;
        logic [31:0] quotient;
    } row_t;

    logic clk;
    logic rst_n;

    fdt_in_if  in_ch ();
    fdt_out_if out_ch ();

    float_divide_truncating_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    logic [31:0] quotient_queue[$];
    int unsigned error_count;
    int unsigned idle_cycles;
    int unsigned stall_cycles;

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Restoring divide of two mantissas that carry the hidden bit.
    function automatic logic [31:0] mantissa_quotient(logic [31:0] num, logic [31:0] den);
        logic [31:0] q;
        logic [31:0] rem;
        q = '0;
        rem = num;
        for (int i = 0; i < 32; i++)
        begin
            q = {q[30:0], rem >= den};
            if (rem >= den)
                rem = rem - den;
            rem = rem << 1;
        end
        return q;
    endfunction

    // Predicted truncated quotient of two single-precision patterns.
    function automatic logic [31:0] divide_truncated(logic [31:0] a, logic [31:0] b);
        logic [31:0] q;
        logic [31:0] r;
        logic        norm;
        if ((a & 32'h7FFF_FFFF) == 0)
            return a;
        if ((b & 32'h7FFF_FFFF) == 0)
            return fdt_pkg::PosInf;
        q = mantissa_quotient((a & fdt_pkg::FracMask) | fdt_pkg::HiddenBit,
                              (b & fdt_pkg::FracMask) | fdt_pkg::HiddenBit);
        norm = ~q[31];
        if (norm)
            q = q << 1;
        r = (a & fdt_pkg::SeMask) - (b & fdt_pkg::SeMask) + fdt_pkg::ExpBias
            - (norm ? fdt_pkg::HiddenBit : 32'h0);
        r = r | ((q & fdt_pkg::QFrac) >> 8);
        if (a[31] ^ b[31] ^ r[31])
            r = fdt_pkg::PosInf;
        return r;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Random 32-bit pattern: mostly normal numbers, some with extreme fields.
    function automatic logic [31:0] random_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'hFF;
            1: v[30:23] = 8'h00;
            2: v[30:0] = '0;
            3: v[22:0] = $urandom_range(0, 1) ? 23'h7FFFFF : 23'h0;
            default: v[30:23] = 8'(8'd107 + 8'($urandom_range(0, 40)));
        endcase
        return v;
    endfunction

    // Random gap length: mostly zero, sometimes short, a few long.
    function automatic int unsigned gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(5, 30);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // Sends one transaction and records its predicted quotient.
    task automatic send_pair(logic [31:0] a, logic [31:0] b, bit known, logic [31:0] want);
        logic [31:0] predicted;
        int unsigned gap;
        predicted = divide_truncated(a, b);
        if (known && predicted !== want)
            report_mismatch("table", predicted, want);
        gap = gap_length();
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {b, a};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        quotient_queue.push_back(known ? want : predicted);
    endtask

    // Receiver: short and long stalls, compares every transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_cycles <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (quotient_queue.size() == 0)
                    report_mismatch("unexpected", out_ch.data, 32'h0);
                else if (out_ch.data !== quotient_queue[0])
                    report_mismatch("quotient_bits", out_ch.data, quotient_queue.pop_front());
                else
                    void'(quotient_queue.pop_front());
            end
            if (stall_cycles != 0)
            begin
                out_ch.ready <= 1'b0;
                stall_cycles <= stall_cycles - 1;
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                out_ch.ready <= 1'b0;
                stall_cycles <= $urandom_range(5, 30);
            end
            else
            begin
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Directed table then random stimulus.
    initial
    begin
        row_t table_rows [NumRows];
        logic [31:0] a;
        logic [31:0] b;
        error_count = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;

        // Zero dividend, zero divisor, exact results and extremes.
        table_rows = '{
            '{32'h0000_0000, 32'h3F80_0000, 1'b1, 32'h0000_0000},
            '{32'h8000_0000, 32'h4000_0000, 1'b1, 32'h8000_0000},
            '{32'h8000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000},
            '{32'h3F80_0000, 32'h0000_0000, 1'b1, fdt_pkg::PosInf},
            '{32'hBF80_0000, 32'h8000_0000, 1'b1, fdt_pkg::PosInf},
            '{32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h3F80_0000},
            '{32'h4000_0000, 32'h3F80_0000, 1'b1, 32'h4000_0000},
            '{32'hC000_0000, 32'h3F80_0000, 1'b1, 32'hC000_0000},
            '{32'h3F80_0000, 32'h4000_0000, 1'b1, 32'h3F00_0000},
            '{32'h3F80_0000, 32'h4040_0000, 1'b0, 32'h0},
            '{32'h7F7F_FFFF, 32'h0080_0000, 1'b0, 32'h0},
            '{32'h0080_0000, 32'h7F7F_FFFF, 1'b0, 32'h0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
            '{32'h7F80_0000, 32'h3F80_0000, 1'b0, 32'h0},
            '{32'h7FC0_0000, 32'hFF80_0000, 1'b0, 32'h0},
            '{32'h0000_0001, 32'h007F_FFFF, 1'b0, 32'h0},
            '{32'h3FFF_FFFF, 32'h3F80_0001, 1'b0, 32'h0},
            '{32'hBF80_0000, 32'hBF80_0000, 1'b1, 32'h3F80_0000},
            '{32'h8000_0001, 32'h0000_0001, 1'b0, 32'h0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
            send_pair(table_rows[i].dividend, table_rows[i].divisor,
                      table_rows[i].known, table_rows[i].quotient);

        // Hold off until the pipeline has drained.
        in_ch.valid <= 1'b0;
        while (quotient_queue.size() != 0)
            @(posedge clk);

        for (int n = 0; n < NumRandom; n++)
        begin
            a = random_float();
            b = random_float();
            send_pair(a, b, 1'b0, 32'h0);
        end
        in_ch.valid <= 1'b0;

        while (quotient_queue.size() != 0)
            @(posedge clk);
        repeat (LatencyCyc + 5) @(posedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
